/* design/assert_macros.svh */
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an expression at every clock edge outside reset.
`define TCW_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define TCW_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

/* design/tcw_pkg.sv */
// Package: widths, codes, command type and defaults of the text console writer.
package tcw_pkg;

	localparam int COLUMNS_DEFAULT = 80;
	localparam int ROWS_DEFAULT    = 25;

	localparam int ROW_W   = 5;
	localparam int COL_W   = 7;
	localparam int CHAR_W  = 8;
	localparam int CELL_W  = 16;
	localparam int COLOR_W = 4;
	localparam int TAB_W   = 5;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 5;

	localparam logic [CFG_INDEX_W-1:0] CFG_FOREGROUND = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_BACKGROUND = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_TAB_SIZE   = 2'd2;

	localparam logic [COLOR_W-1:0] FOREGROUND_RESET = 4'd7;
	localparam logic [COLOR_W-1:0] BACKGROUND_RESET = 4'd0;
	localparam logic [TAB_W-1:0]   TAB_SIZE_RESET   = 5'd4;

	localparam logic OPC_PUT  = 1'b0;
	localparam logic OPC_READ = 1'b1;

	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_FORMFEED  = 8'h0C;
	localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

	// Blank grey-on-black cell written by the power-up clearing pass.
	localparam logic [CELL_W-1:0] CELL_RESET = 16'h0720;

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [2:0] {
		CMD_GLYPH     = 3'd0,
		CMD_NEWLINE   = 3'd1,
		CMD_RETURN    = 3'd2,
		CMD_BACKSPACE = 3'd3,
		CMD_TAB       = 3'd4,
		CMD_FORMFEED  = 3'd5,
		CMD_READ      = 3'd6
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [CHAR_W-1:0] ch;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic              in_range;
	} cmd_t;

endpackage

/* design/tcw_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* design/tcw_cmd_queue.sv */
// Short command queue between the classifying front and the executing back.
module tcw_cmd_queue #(
	parameter int DEPTH = tcw_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tcw_pkg::cmd_t push_data,
	input  logic          pop,
	output tcw_pkg::cmd_t pop_data,
	output logic          empty,
	output logic          full
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	tcw_pkg::cmd_t    entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign empty    = (count_q == '0);
	assign full     = (count_q == CNT_W'(DEPTH));
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

/* design/tcw_front.sv */
// Front end: input handshake, classification of items into commands.
module tcw_front #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
	parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       opcode,
	input  logic [tcw_pkg::CHAR_W-1:0] character,
	input  logic [tcw_pkg::ROW_W-1:0]  read_row,
	input  logic [tcw_pkg::COL_W-1:0]  read_column,
	input  logic                       queue_full,
	input  logic                       init_busy,
	output logic                       push,
	output tcw_pkg::cmd_t              cmd
);

	localparam int ROWC_W = tcw_pkg::ROW_W + 1;
	localparam int COLC_W = tcw_pkg::COL_W + 1;
	localparam logic [ROWC_W-1:0] ROWS_L    = ROWC_W'(ROWS);
	localparam logic [COLC_W-1:0] COLUMNS_L = COLC_W'(COLUMNS);

	// Hold off while the queue is full or the buffer is still being cleared.
	assign in_stall = queue_full || init_busy;
	assign push     = in_valid && !in_stall;

	always_comb begin
		cmd.ch       = character;
		cmd.row      = read_row;
		cmd.col      = read_column;
		cmd.in_range = ({1'b0, read_row} < ROWS_L) && ({1'b0, read_column} < COLUMNS_L);
		if (opcode == tcw_pkg::OPC_READ) begin
			cmd.kind = tcw_pkg::CMD_READ;
		end else begin
			unique case (character)
				tcw_pkg::CH_NEWLINE:   cmd.kind = tcw_pkg::CMD_NEWLINE;
				tcw_pkg::CH_RETURN:    cmd.kind = tcw_pkg::CMD_RETURN;
				tcw_pkg::CH_BACKSPACE: cmd.kind = tcw_pkg::CMD_BACKSPACE;
				tcw_pkg::CH_TAB:       cmd.kind = tcw_pkg::CMD_TAB;
				tcw_pkg::CH_FORMFEED:  cmd.kind = tcw_pkg::CMD_FORMFEED;
				default:               cmd.kind = tcw_pkg::CMD_GLYPH;
			endcase
		end
	end

endmodule

/* design/tcw_back.sv */
// Back end: command sequencer, cursor, buffer sweeps, result register.
module tcw_back #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
	parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	input  tcw_pkg::cmd_t               cmd,
	output logic                        pop,
	input  logic [tcw_pkg::COLOR_W-1:0] foreground_color,
	input  logic [tcw_pkg::COLOR_W-1:0] background_color,
	input  logic [tcw_pkg::TAB_W-1:0]   tab_size,
	output logic                        init_busy,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [tcw_pkg::ROW_W-1:0]   cursor_row,
	output logic [tcw_pkg::COL_W-1:0]   cursor_column,
	output logic [tcw_pkg::CELL_W-1:0]  cell_entry
);

	localparam int ROW_W  = tcw_pkg::ROW_W;
	localparam int COL_W  = tcw_pkg::COL_W;
	localparam int TAB_W  = tcw_pkg::TAB_W;
	localparam int CELL_W = tcw_pkg::CELL_W;
	localparam int CELLS  = COLUMNS * ROWS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int RQ_W   = ROW_W + 1;
	localparam int TCOL_W = COL_W + 1;
	localparam int DIV_W  = $clog2(COL_W);
	localparam int TAB_ROW_STEPS = (COLUMNS - 1 + (2 ** TAB_W) - 1) / COLUMNS;
	localparam int RADD_W = $clog2(TAB_ROW_STEPS + 1);

	localparam logic [ADDR_W-1:0] LAST_ADDR    = ADDR_W'(CELLS - 1);
	localparam logic [ADDR_W-1:0] BOTTOM_FIRST = ADDR_W'(CELLS - COLUMNS);
	localparam logic [ADDR_W-1:0] COPY_FIRST   = ADDR_W'(COLUMNS);
	localparam logic [ADDR_W-1:0] ROW_STRIDE   = ADDR_W'(COLUMNS);
	localparam logic [COL_W-1:0]  COL_LAST     = COL_W'(COLUMNS - 1);
	localparam logic [RQ_W-1:0]   ROWS_L       = RQ_W'(ROWS);
	localparam logic [TCOL_W-1:0] COLUMNS_T    = TCOL_W'(COLUMNS);
	localparam logic [DIV_W-1:0]  DIV_FIRST    = DIV_W'(COL_W - 1);

	typedef enum logic [9:0] {
		S_INIT    = 10'b0000000001,
		S_IDLE    = 10'b0000000010,
		S_RDATA   = 10'b0000000100,
		S_SETTLE  = 10'b0000001000,
		S_COPY    = 10'b0000010000,
		S_DRAIN   = 10'b0000100000,
		S_BLANK   = 10'b0001000000,
		S_TABDIV  = 10'b0010000000,
		S_TABMOVE = 10'b0100000000,
		S_RESULT  = 10'b1000000000
	} state_t;

	state_t              state_q;
	logic [RQ_W-1:0]     row_q;
	logic [COL_W-1:0]    col_q;
	logic [ADDR_W-1:0]   sweep_q;
	logic [ADDR_W-1:0]   copy_wr_s1;
	logic                copy_pend_s1;
	logic                blank_scroll_q;
	logic                in_range_q;
	logic [TAB_W-1:0]    rem_q;
	logic [DIV_W-1:0]    div_bit_q;
	logic [CELL_W-1:0]   cell_q;
	logic                out_valid_q;
	logic [ROW_W-1:0]    out_row_q;
	logic [COL_W-1:0]    out_col_q;
	logic [CELL_W-1:0]   out_cell_q;

	logic                ram_wr_en;
	logic [ADDR_W-1:0]   ram_wr_addr;
	logic [CELL_W-1:0]   ram_wr_data;
	logic                ram_rd_en;
	logic [ADDR_W-1:0]   ram_rd_addr;
	logic [CELL_W-1:0]   ram_rd_data;

	logic [CELL_W-1:0]   blank_cell;
	logic [CELL_W-1:0]   glyph_cell;
	logic [ADDR_W-1:0]   cursor_addr;
	logic [ADDR_W-1:0]   read_addr;
	logic [TAB_W-1:0]    step;
	logic [TAB_W:0]      trial;
	logic [TAB_W:0]      trial_sub;
	logic [TAB_W-1:0]    rem_next;
	logic [TCOL_W-1:0]   tab_col;
	logic [RADD_W-1:0]   tab_rows;
	logic                out_free;

	assign blank_cell  = {background_color, foreground_color, tcw_pkg::CH_SPACE};
	assign glyph_cell  = {background_color, foreground_color, cmd.ch};
	assign cursor_addr = ADDR_W'(row_q) * ROW_STRIDE + ADDR_W'(col_q);
	assign read_addr   = cmd.in_range ? ADDR_W'(cmd.row) * ROW_STRIDE + ADDR_W'(cmd.col) : '0;
	assign step        = (tab_size == '0) ? TAB_W'(1) : tab_size;

	// One bit of the column remainder per cycle.
	assign trial     = {rem_q, col_q[div_bit_q]};
	assign trial_sub = trial - {1'b0, step};
	assign rem_next  = (trial >= {1'b0, step}) ? trial_sub[TAB_W-1:0] : trial[TAB_W-1:0];

	always_comb begin
		tab_col  = {1'b0, col_q} + TCOL_W'(step) - TCOL_W'(rem_q);
		tab_rows = '0;
		for (int i = 0; i < TAB_ROW_STEPS; i++) begin
			if (tab_col >= COLUMNS_T) begin
				tab_col  = tab_col - COLUMNS_T;
				tab_rows = tab_rows + RADD_W'(1);
			end
		end
	end

	assign pop       = (state_q == S_IDLE) && cmd_valid;
	assign init_busy = (state_q == S_INIT);
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		ram_wr_en   = 1'b0;
		ram_wr_addr = sweep_q;
		ram_wr_data = blank_cell;
		ram_rd_en   = 1'b0;
		ram_rd_addr = sweep_q;
		unique case (state_q)
			S_INIT: begin
				ram_wr_en   = 1'b1;
				ram_wr_data = tcw_pkg::CELL_RESET;
			end
			S_IDLE: begin
				if (cmd_valid && cmd.kind == tcw_pkg::CMD_GLYPH) begin
					ram_wr_en   = 1'b1;
					ram_wr_addr = cursor_addr;
					ram_wr_data = glyph_cell;
				end
				if (cmd_valid && cmd.kind == tcw_pkg::CMD_READ) begin
					ram_rd_en   = 1'b1;
					ram_rd_addr = read_addr;
				end
			end
			S_COPY: begin
				ram_rd_en   = 1'b1;
				ram_wr_en   = copy_pend_s1;
				ram_wr_addr = copy_wr_s1;
				ram_wr_data = ram_rd_data;
			end
			S_DRAIN: begin
				ram_wr_en   = copy_pend_s1;
				ram_wr_addr = copy_wr_s1;
				ram_wr_data = ram_rd_data;
			end
			S_BLANK: begin
				ram_wr_en = 1'b1;
			end
			default: begin
			end
		endcase
	end

	tcw_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELLS)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_INIT;
			row_q          <= '0;
			col_q          <= '0;
			sweep_q        <= '0;
			copy_pend_s1   <= 1'b0;
			blank_scroll_q <= 1'b0;
			div_bit_q      <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			copy_pend_s1 <= 1'b0;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_INIT: begin
					sweep_q <= sweep_q + ADDR_W'(1);
					if (sweep_q == LAST_ADDR) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd_valid) begin
						unique case (cmd.kind)
							tcw_pkg::CMD_GLYPH: begin
								if (col_q == COL_LAST) begin
									col_q   <= '0;
									row_q   <= row_q + RQ_W'(1);
									state_q <= S_SETTLE;
								end else begin
									col_q   <= col_q + COL_W'(1);
									state_q <= S_RESULT;
								end
							end
							tcw_pkg::CMD_NEWLINE: begin
								col_q   <= '0;
								row_q   <= row_q + RQ_W'(1);
								state_q <= S_SETTLE;
							end
							tcw_pkg::CMD_RETURN: begin
								col_q   <= '0;
								state_q <= S_RESULT;
							end
							tcw_pkg::CMD_BACKSPACE: begin
								if (col_q != '0) begin
									col_q <= col_q - COL_W'(1);
								end
								state_q <= S_RESULT;
							end
							tcw_pkg::CMD_TAB: begin
								div_bit_q <= DIV_FIRST;
								state_q   <= S_TABDIV;
							end
							tcw_pkg::CMD_FORMFEED: begin
								row_q          <= '0;
								col_q          <= '0;
								sweep_q        <= '0;
								blank_scroll_q <= 1'b0;
								state_q        <= S_BLANK;
							end
							tcw_pkg::CMD_READ: begin
								state_q <= S_RDATA;
							end
							default: begin
								state_q <= S_RESULT;
							end
						endcase
					end
				end
				S_RDATA: begin
					state_q <= S_RESULT;
				end
				S_SETTLE: begin
					if (row_q >= ROWS_L) begin
						sweep_q <= COPY_FIRST;
						state_q <= S_COPY;
					end else begin
						state_q <= S_RESULT;
					end
				end
				S_COPY: begin
					copy_pend_s1 <= 1'b1;
					sweep_q      <= sweep_q + ADDR_W'(1);
					if (sweep_q == LAST_ADDR) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					sweep_q        <= BOTTOM_FIRST;
					blank_scroll_q <= 1'b1;
					state_q        <= S_BLANK;
				end
				S_BLANK: begin
					sweep_q <= sweep_q + ADDR_W'(1);
					if (sweep_q == LAST_ADDR) begin
						if (blank_scroll_q) begin
							row_q   <= row_q - RQ_W'(1);
							state_q <= S_SETTLE;
						end else begin
							state_q <= S_RESULT;
						end
					end
				end
				S_TABDIV: begin
					div_bit_q <= div_bit_q - DIV_W'(1);
					if (div_bit_q == '0) begin
						state_q <= S_TABMOVE;
					end
				end
				S_TABMOVE: begin
					col_q   <= tab_col[COL_W-1:0];
					row_q   <= row_q + RQ_W'(tab_rows);
					state_q <= S_SETTLE;
				end
				S_RESULT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		if (pop) begin
			in_range_q <= cmd.in_range;
			cell_q     <= '0;
			rem_q      <= '0;
		end
		if (state_q == S_RDATA) begin
			cell_q <= in_range_q ? ram_rd_data : '0;
		end
		if (state_q == S_TABDIV) begin
			rem_q <= rem_next;
		end
		if (state_q == S_COPY) begin
			copy_wr_s1 <= sweep_q - ROW_STRIDE;
		end
		if (state_q == S_RESULT && out_free) begin
			out_row_q  <= row_q[ROW_W-1:0];
			out_col_q  <= col_q;
			out_cell_q <= cell_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign cursor_row    = out_row_q;
	assign cursor_column = out_col_q;
	assign cell_entry    = out_cell_q;

endmodule

/* design/text_console_writer.sv */
// Top level of the text console writer: configuration registers and block wiring.
// Input channel (in_valid / in_stall): one transaction carries opcode, character,
//   read_row and read_column. Opcode put prints a byte or runs a control code
//   (newline, carriage return, backspace, tab, form feed); opcode read fetches one
//   cell of the ROWS x COLUMNS buffer.
// Output channel (out_valid / out_stall): exactly one transaction per input
//   transaction, in order, with the cursor after the item and the cell read
//   (zero for put items and for reads outside the buffer).
// Configuration port (cfg_write, cfg_index, cfg_data): colors and tab size, to be
//   written by the user only while idle (unchecked); unknown indexes are dropped.
// Items run one at a time: the back end takes a command from the queue only
//   after the result of the last one is registered. A tab finds the column
//   remainder one bit per cycle. A scroll copies the buffer up a row and blanks
//   the bottom row, one cell a cycle through the single buffer RAM; a form feed
//   blanks the whole buffer and homes the cursor.
// Reset: the cursor homes, registers take their defaults and a clearing pass
//   writes a blank grey-on-black cell to every address of the buffer, during
//   which in_stall is held high.
// Receiver stall: the result register holds; the command queue still fills
//   to its depth of two commands before in_stall rises.
module text_console_writer #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
	parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [tcw_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [tcw_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            opcode,
	input  logic [tcw_pkg::CHAR_W-1:0]      character,
	input  logic [tcw_pkg::ROW_W-1:0]       read_row,
	input  logic [tcw_pkg::COL_W-1:0]       read_column,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [tcw_pkg::ROW_W-1:0]       cursor_row,
	output logic [tcw_pkg::COL_W-1:0]       cursor_column,
	output logic [tcw_pkg::CELL_W-1:0]      cell_entry
);

	// Configuration registers.
	logic [tcw_pkg::COLOR_W-1:0] foreground_q;
	logic [tcw_pkg::COLOR_W-1:0] background_q;
	logic [tcw_pkg::TAB_W-1:0]   tab_size_q;

	// Front to queue to back.
	logic          push;
	logic          pop;
	logic          queue_empty;
	logic          queue_full;
	logic          init_busy;
	tcw_pkg::cmd_t front_cmd;
	tcw_pkg::cmd_t head_cmd;

	// Take a register write at any edge with cfg_write high; drop unknown indexes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreground_q <= tcw_pkg::FOREGROUND_RESET;
			background_q <= tcw_pkg::BACKGROUND_RESET;
			tab_size_q   <= tcw_pkg::TAB_SIZE_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				tcw_pkg::CFG_FOREGROUND: foreground_q <= cfg_data[tcw_pkg::COLOR_W-1:0];
				tcw_pkg::CFG_BACKGROUND: background_q <= cfg_data[tcw_pkg::COLOR_W-1:0];
				tcw_pkg::CFG_TAB_SIZE:   tab_size_q   <= cfg_data[tcw_pkg::TAB_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Classify each accepted transaction into a command.
	tcw_front #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_front (
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.character   (character),
		.read_row    (read_row),
		.read_column (read_column),
		.queue_full  (queue_full),
		.init_busy   (init_busy),
		.push        (push),
		.cmd         (front_cmd)
	);

	// Decouple the front from long buffer sweeps in the back.
	tcw_cmd_queue #(
		.DEPTH(tcw_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (front_cmd),
		.pop       (pop),
		.pop_data  (head_cmd),
		.empty     (queue_empty),
		.full      (queue_full)
	);

	// Execute commands against the cell buffer and cursor; own the result register.
	tcw_back #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd_valid        (!queue_empty),
		.cmd              (head_cmd),
		.pop              (pop),
		.foreground_color (foreground_q),
		.background_color (background_q),
		.tab_size         (tab_size_q),
		.init_busy        (init_busy),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.cursor_row       (cursor_row),
		.cursor_column    (cursor_column),
		.cell_entry       (cell_entry)
	);

endmodule

/* design/tcw_checker.sv */
// Port-level checker for the text console writer, bound to the top level.
`include "assert_macros.svh"

module tcw_checker #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
	parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [tcw_pkg::ROW_W-1:0]  cursor_row,
	input logic [tcw_pkg::COL_W-1:0]  cursor_column,
	input logic [tcw_pkg::CELL_W-1:0] cell_entry
);

	logic [3:0] pending_q;
	logic       in_take;
	logic       out_take;

	assign in_take  = in_valid && !in_stall;
	assign out_take = out_valid && !out_stall;

	// Count transactions accepted but not yet answered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_take && !out_take) begin
			pending_q <= pending_q + 4'd1;
		end else if (out_take && !in_take) begin
			pending_q <= pending_q - 4'd1;
		end
	end

	`TCW_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(cursor_row) && $stable(cursor_column) && $stable(cell_entry), "stalled result changed")
	`TCW_ASSERT_ALWAYS(a_cursor_range, !out_valid || (cursor_row < ROWS && cursor_column < COLUMNS), "cursor outside buffer")
	`TCW_ASSERT_ALWAYS(a_no_extra_result, !out_valid || pending_q != 4'd0, "result without an accepted item")

endmodule

bind text_console_writer tcw_checker #(
	.COLUMNS(COLUMNS),
	.ROWS   (ROWS)
) u_tcw_checker (.*);
